FILE: sv/fwa_pkg.sv
// Shared types, constants and helpers of the frame window analyzer.
package fwa_pkg;

  localparam int unsigned WINDOW    = 60;
  localparam int unsigned MIN_VALID = 10;

  localparam int unsigned T_W    = 20;
  localparam int unsigned F_W    = 16;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned IDX_W  = $clog2(WINDOW);
  localparam int unsigned SUMF_W = F_W + CNT_W;
  localparam int unsigned SUMT_W = T_W + CNT_W;
  localparam int unsigned SQ_W   = 2 * T_W + CNT_W;
  localparam int unsigned SPR_W  = 2 * SUMT_W;
  localparam int unsigned ROOT_W = SPR_W / 2;
  localparam int unsigned DIV_W  = SUMT_W;
  localparam int unsigned DVS_W  = (CNT_W > 5) ? CNT_W : 5;

  localparam int unsigned DROP_LIMIT_US = 33330;
  localparam int unsigned RANK_NUM      = 19;
  localparam int unsigned RANK_DEN      = 20;
  // floor(x / 20) as (x * 3277) >> 16, exact for x up to 19 * WINDOW
  localparam int unsigned RANK_RECIP    = 3277;
  localparam int unsigned RANK_SHIFT    = 16;

  typedef enum logic [2:0] {
    CLS_NONE  = 3'd0,
    CLS_GPU   = 3'd1,
    CLS_CPU   = 3'd2,
    CLS_MEM   = 3'd3,
    CLS_VSYNC = 3'd4
  } fwa_cls_e;

  // One classified frame, front to back
  typedef struct packed {
    logic [T_W-1:0] ft;
    logic [F_W-1:0] fps;
    fwa_cls_e       cls;
    logic           draws;
    logic           cache;
    logic           frag;
    logic           switches;
  } fwa_job_t;

  // One result transaction
  typedef struct packed {
    fwa_cls_e       cls;
    logic           draws;
    logic           cache;
    logic           frag;
    logic           switches;
    logic           valid;
    logic [F_W-1:0] mean_fps;
    logic [T_W-1:0] p95;
    logic [T_W-1:0] stddev;
    logic [7:0]     drops;
    logic [7:0]     stutters;
  } fwa_res_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PUSH,
    ST_STAT,
    ST_MUL,
    ST_SPR,
    ST_SQ_GO,
    ST_SQ_W,
    ST_D1_GO,
    ST_D1_W,
    ST_D2_GO,
    ST_D2_W,
    ST_D3_GO,
    ST_CAND0,
    ST_CAND,
    ST_CWAIT,
    ST_INNER,
    ST_CHECK,
    ST_OUT
  } fwa_state_e;

  // Ring index increment with wrap
  function automatic logic [IDX_W-1:0] fwa_wrap(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    if (p == IDX_W'(WINDOW - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

endpackage

FILE: sv/fwa_front.sv
// Front end: accepts frames, classifies them and queues them for the back end.
module fwa_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [19:0]           frame_time_us_i,
  input  logic [19:0]           gpu_time_us_i,
  input  logic [15:0]           frames_per_sec_i,
  input  logic [9:0]            cpu_load_tenths_i,
  input  logic [39:0]           mem_allocated_i,
  input  logic [39:0]           mem_reserved_i,
  input  logic [19:0]           draw_call_count_i,
  input  logic [10:0]           cache_hit_ratio_i,
  input  logic [10:0]           fragmentation_ratio_i,
  input  logic [15:0]           shader_switch_count_i,
  output logic                  job_valid_o,
  input  logic                  job_pop_i,
  output fwa_pkg::fwa_job_t     job_o
);

  fwa_pkg::fwa_job_t job_in;
  fwa_pkg::fwa_job_t ent_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  logic [23:0] gpu10, ft9;
  logic [44:0] alloc20, resv19;
  logic [14:0] cache10, frag10;
  logic        vsync;

  // Classification of the incoming frame
  always_comb begin
    gpu10   = 24'(gpu_time_us_i) * 24'd10;
    ft9     = 24'(frame_time_us_i) * 24'd9;
    alloc20 = 45'(mem_allocated_i) * 45'd20;
    resv19  = 45'(mem_reserved_i) * 45'd19;
    cache10 = 15'(cache_hit_ratio_i) * 15'd10;
    frag10  = 15'(fragmentation_ratio_i) * 15'd10;
    vsync   = (frame_time_us_i > 20'd16170 && frame_time_us_i < 20'd17170) ||
              (frame_time_us_i > 20'd32830 && frame_time_us_i < 20'd33830);
    job_in.ft  = frame_time_us_i;
    job_in.fps = frames_per_sec_i;
    if (gpu10 > ft9) job_in.cls = fwa_pkg::CLS_GPU;
    else if (cpu_load_tenths_i > 10'd900) job_in.cls = fwa_pkg::CLS_CPU;
    else if (alloc20 > resv19) job_in.cls = fwa_pkg::CLS_MEM;
    else if (vsync) job_in.cls = fwa_pkg::CLS_VSYNC;
    else job_in.cls = fwa_pkg::CLS_NONE;
    job_in.draws    = draw_call_count_i > 20'd2000;
    job_in.cache    = cache10 < 15'd7168;
    job_in.frag     = frag10 > 15'd3072;
    job_in.switches = shader_switch_count_i > 16'd100;
  end

  // Two-entry queue toward the back end
  assign in_stall_o  = (cnt_q == 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = ent_q[rd_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = job_pop_i && job_valid_o;

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = pop ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_q] <= job_in;
  end

endmodule

FILE: sv/fwa_div.sv
// Restoring divider, one quotient bit per cycle.
module fwa_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [fwa_pkg::DIV_W-1:0] dividend_i,
  input  logic [fwa_pkg::DVS_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [fwa_pkg::DIV_W-1:0] quot_o
);

  localparam int unsigned CW = $clog2(fwa_pkg::DIV_W + 1);

  logic [fwa_pkg::DIV_W-1:0] dvd_q;
  logic [fwa_pkg::DVS_W-1:0] dvs_q, rem_q;
  logic [fwa_pkg::DVS_W:0]   rs;
  logic                      ge;
  logic [CW-1:0]             cnt_q;
  logic                      busy_q, done_q;

  always_comb begin
    rs = {rem_q, dvd_q[fwa_pkg::DIV_W-1]};
    ge = rs >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(fwa_pkg::DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? fwa_pkg::DVS_W'(rs - {1'b0, dvs_q}) : rs[fwa_pkg::DVS_W-1:0];
      dvd_q <= {dvd_q[fwa_pkg::DIV_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

FILE: sv/fwa_sqrt.sv
// Integer square root, one result bit per cycle.
module fwa_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fwa_pkg::SPR_W-1:0]  value_i,
  output logic                       done_o,
  output logic [fwa_pkg::ROOT_W-1:0] root_o
);

  localparam int unsigned W = fwa_pkg::SPR_W;

  logic [W-1:0] v_q, root_q, bit_q, sum;
  logic         busy_q, done_q;

  assign sum = root_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Digit recurrence
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= value_i;
      root_q <= '0;
      bit_q  <= W'(1) << (W - 2);
    end else if (busy_q) begin
      if (v_q >= sum) begin
        v_q    <= v_q - sum;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q[fwa_pkg::ROOT_W-1:0];

endmodule

FILE: sv/fwa_back.sv
// Back end: frame window ring, window statistics sequencer and result register.
module fwa_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_pop_o,
  input  fwa_pkg::fwa_job_t job_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fwa_pkg::fwa_res_t res_o
);

  localparam int unsigned CNT_W = fwa_pkg::CNT_W;
  localparam int unsigned IDX_W = fwa_pkg::IDX_W;
  localparam int unsigned T_W   = fwa_pkg::T_W;
  localparam int unsigned F_W   = fwa_pkg::F_W;

  fwa_pkg::fwa_state_e state_q, state_d;

  logic [T_W-1:0] time_mem [fwa_pkg::WINDOW];
  logic [F_W-1:0] fps_mem  [fwa_pkg::WINDOW];
  logic [T_W-1:0] rd_t_q;
  logic [F_W-1:0] rd_f_q;

  logic [IDX_W-1:0] oldest_q, oldest_d, ptr_q, ptr_d, cptr_q, cptr_d, wslot;
  logic [IDX_W:0]   wsum;
  logic [CNT_W-1:0] held_q, held_d, n_q, n_d, cnt_q, cnt_d;
  logic [CNT_W-1:0] lt_q, lt_d, eq_q, eq_d, k_q, k_d;
  logic [CNT_W-1:0] drops_q, drops_d, stut_q, stut_d;
  logic [CNT_W:0]   lte;
  logic             pend_q, pend_d, first_q, first_d, vld_q, vld_d, issue, hit;
  logic             ov_q, ov_d, load;
  logic [T_W-1:0]   prev_q, prev_d, cand_q, cand_d, p95_q, p95_d;
  logic [T_W-1:0]   sd_q, sd_d;
  logic [F_W-1:0]   mean_q, mean_d;
  logic [fwa_pkg::SUMF_W-1:0] sumf_q, sumf_d;
  logic [fwa_pkg::SUMT_W-1:0] sumt_q, sumt_d;
  logic [fwa_pkg::SQ_W-1:0]   sq_q, sq_d;
  logic [fwa_pkg::SPR_W-1:0]  pa_q, pa_d, pb_q, pb_d, spr_q, spr_d;
  logic [10:0]                rank_x;
  logic [22:0]                rank_p;
  fwa_pkg::fwa_job_t job_q, job_d;
  fwa_pkg::fwa_res_t res_q, res_d;

  logic                        div_start, div_done, sq_start, sq_done;
  logic [fwa_pkg::DIV_W-1:0]   div_dvd, div_quot;
  logic [fwa_pkg::DVS_W-1:0]   div_dvs;
  logic [fwa_pkg::ROOT_W-1:0]  root;

  fwa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  fwa_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (spr_q),
    .done_o  (sq_done),
    .root_o  (root)
  );

  // Write slot of the new frame
  always_comb begin
    wsum = (IDX_W + 1)'(oldest_q) + (IDX_W + 1)'(held_q[IDX_W-1:0]);
    if (wsum >= (IDX_W + 1)'(fwa_pkg::WINDOW))
      wslot = IDX_W'(wsum - (IDX_W + 1)'(fwa_pkg::WINDOW));
    else
      wslot = wsum[IDX_W-1:0];
  end

  // Window memories
  always_ff @(posedge clk_i) begin
    if (state_q == fwa_pkg::ST_PUSH && held_q != CNT_W'(fwa_pkg::WINDOW)) begin
      time_mem[wslot] <= job_q.ft;
      fps_mem[wslot]  <= job_q.fps;
    end else if (state_q == fwa_pkg::ST_PUSH) begin
      time_mem[oldest_q] <= job_q.ft;
      fps_mem[oldest_q]  <= job_q.fps;
    end
    rd_t_q <= time_mem[ptr_q];
    rd_f_q <= fps_mem[ptr_q];
  end

  assign issue = (cnt_q != n_q);
  assign lte   = (CNT_W + 1)'(lt_q) + (CNT_W + 1)'(eq_q);
  assign hit   = (lt_q <= k_q) && ((CNT_W + 1)'(k_q) < lte);
  assign load  = !ov_q || !out_stall_i;

  // Percentile rank floor(n * 19 / 20) by reciprocal multiply
  assign rank_x = 11'(n_q) * 11'(fwa_pkg::RANK_NUM);
  assign rank_p = 23'(rank_x) * 23'(fwa_pkg::RANK_RECIP);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    oldest_d  = oldest_q;
    held_d    = held_q;
    n_d       = n_q;
    vld_d     = vld_q;
    job_d     = job_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    pend_d    = 1'b0;
    first_d   = first_q;
    prev_d    = prev_q;
    sumf_d    = sumf_q;
    sumt_d    = sumt_q;
    sq_d      = sq_q;
    drops_d   = drops_q;
    stut_d    = stut_q;
    pa_d      = pa_q;
    pb_d      = pb_q;
    spr_d     = spr_q;
    mean_d    = mean_q;
    sd_d      = sd_q;
    k_d       = k_q;
    cptr_d    = cptr_q;
    cand_d    = cand_q;
    lt_d      = lt_q;
    eq_d      = eq_q;
    p95_d     = p95_q;
    res_d     = res_q;
    ov_d      = ov_q && out_stall_i;
    job_pop_o = 1'b0;
    div_start = 1'b0;
    sq_start  = 1'b0;
    div_dvd   = '0;
    div_dvs   = fwa_pkg::DVS_W'(n_q);

    unique case (state_q)
      fwa_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          state_d   = fwa_pkg::ST_PUSH;
        end
      end
      fwa_pkg::ST_PUSH: begin
        if (held_q != CNT_W'(fwa_pkg::WINDOW)) begin
          held_d = held_q + 1'b1;
        end else begin
          oldest_d = fwa_pkg::fwa_wrap(oldest_q);
        end
        n_d   = held_d;
        vld_d = 32'(held_d) >= fwa_pkg::MIN_VALID;
        cnt_d   = '0;
        ptr_d   = oldest_d;
        first_d = 1'b1;
        sumf_d  = '0;
        sumt_d  = '0;
        sq_d    = '0;
        drops_d = '0;
        stut_d  = '0;
        state_d = vld_d ? fwa_pkg::ST_STAT : fwa_pkg::ST_OUT;
      end
      // Sweep for sums and counts, one entry a cycle
      fwa_pkg::ST_STAT: begin
        if (issue) begin
          cnt_d  = cnt_q + 1'b1;
          ptr_d  = fwa_pkg::fwa_wrap(ptr_q);
          pend_d = 1'b1;
        end
        if (pend_q) begin
          sumf_d = sumf_q + fwa_pkg::SUMF_W'(rd_f_q);
          sumt_d = sumt_q + fwa_pkg::SUMT_W'(rd_t_q);
          sq_d   = sq_q + fwa_pkg::SQ_W'(rd_t_q) * fwa_pkg::SQ_W'(rd_t_q);
          if (!first_q) begin
            if (rd_t_q > T_W'(fwa_pkg::DROP_LIMIT_US)) drops_d = drops_q + 1'b1;
            if ({1'b0, rd_t_q} > {prev_q, 1'b0}) stut_d = stut_q + 1'b1;
          end
          prev_d  = rd_t_q;
          first_d = 1'b0;
        end
        if (!issue && !pend_q) state_d = fwa_pkg::ST_MUL;
      end
      fwa_pkg::ST_MUL: begin
        pa_d    = fwa_pkg::SPR_W'(n_q) * fwa_pkg::SPR_W'(sq_q);
        pb_d    = fwa_pkg::SPR_W'(sumt_q) * fwa_pkg::SPR_W'(sumt_q);
        state_d = fwa_pkg::ST_SPR;
      end
      fwa_pkg::ST_SPR: begin
        spr_d   = pa_q - pb_q;
        state_d = fwa_pkg::ST_SQ_GO;
      end
      fwa_pkg::ST_SQ_GO: begin
        sq_start = 1'b1;
        state_d  = fwa_pkg::ST_SQ_W;
      end
      fwa_pkg::ST_SQ_W: begin
        if (sq_done) state_d = fwa_pkg::ST_D1_GO;
      end
      // Standard deviation: root / n
      fwa_pkg::ST_D1_GO: begin
        div_dvd   = fwa_pkg::DIV_W'(root);
        div_dvs   = fwa_pkg::DVS_W'(n_q);
        div_start = 1'b1;
        state_d   = fwa_pkg::ST_D1_W;
      end
      fwa_pkg::ST_D1_W: begin
        if (div_done) begin
          sd_d    = T_W'(div_quot);
          state_d = fwa_pkg::ST_D2_GO;
        end
      end
      // Mean fps
      fwa_pkg::ST_D2_GO: begin
        div_dvd   = fwa_pkg::DIV_W'(sumf_q);
        div_dvs   = fwa_pkg::DVS_W'(n_q);
        div_start = 1'b1;
        state_d   = fwa_pkg::ST_D2_W;
      end
      fwa_pkg::ST_D2_W: begin
        if (div_done) begin
          mean_d  = F_W'(div_quot);
          state_d = fwa_pkg::ST_D3_GO;
        end
      end
      // Percentile rank
      fwa_pkg::ST_D3_GO: begin
        k_d     = CNT_W'(rank_p >> fwa_pkg::RANK_SHIFT);
        state_d = fwa_pkg::ST_CAND0;
      end
      fwa_pkg::ST_CAND0: begin
        cptr_d  = oldest_q;
        ptr_d   = oldest_q;
        state_d = fwa_pkg::ST_CAND;
      end
      fwa_pkg::ST_CAND: begin
        state_d = fwa_pkg::ST_CWAIT;
      end
      fwa_pkg::ST_CWAIT: begin
        cand_d  = rd_t_q;
        ptr_d   = oldest_q;
        cnt_d   = '0;
        lt_d    = '0;
        eq_d    = '0;
        state_d = fwa_pkg::ST_INNER;
      end
      // Rank the candidate against the whole window
      fwa_pkg::ST_INNER: begin
        if (issue) begin
          cnt_d  = cnt_q + 1'b1;
          ptr_d  = fwa_pkg::fwa_wrap(ptr_q);
          pend_d = 1'b1;
        end
        if (pend_q) begin
          if (rd_t_q < cand_q) lt_d = lt_q + 1'b1;
          if (rd_t_q == cand_q) eq_d = eq_q + 1'b1;
        end
        if (!issue && !pend_q) state_d = fwa_pkg::ST_CHECK;
      end
      fwa_pkg::ST_CHECK: begin
        if (hit) begin
          p95_d   = cand_q;
          state_d = fwa_pkg::ST_OUT;
        end else begin
          cptr_d  = fwa_pkg::fwa_wrap(cptr_q);
          ptr_d   = cptr_d;
          state_d = fwa_pkg::ST_CAND;
        end
      end
      fwa_pkg::ST_OUT: begin
        if (load) begin
          res_d = '0;
          if (vld_q) begin
            res_d.cls      = job_q.cls;
            res_d.draws    = job_q.draws;
            res_d.cache    = job_q.cache;
            res_d.frag     = job_q.frag;
            res_d.switches = job_q.switches;
            res_d.valid    = 1'b1;
            res_d.mean_fps = mean_q;
            res_d.p95      = p95_q;
            res_d.stddev   = sd_q;
            res_d.drops    = 8'(drops_q);
            res_d.stutters = 8'(stut_q);
          end
          ov_d    = 1'b1;
          state_d = fwa_pkg::ST_IDLE;
        end
      end
      default: state_d = fwa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fwa_pkg::ST_IDLE;
      oldest_q <= '0;
      held_q   <= '0;
      pend_q   <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      oldest_q <= oldest_d;
      held_q   <= held_d;
      pend_q   <= pend_d;
      ov_q     <= ov_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    vld_q   <= vld_d;
    job_q   <= job_d;
    cnt_q   <= cnt_d;
    ptr_q   <= ptr_d;
    first_q <= first_d;
    prev_q  <= prev_d;
    sumf_q  <= sumf_d;
    sumt_q  <= sumt_d;
    sq_q    <= sq_d;
    drops_q <= drops_d;
    stut_q  <= stut_d;
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    spr_q   <= spr_d;
    mean_q  <= mean_d;
    sd_q    <= sd_d;
    k_q     <= k_d;
    cptr_q  <= cptr_d;
    cand_q  <= cand_d;
    lt_q    <= lt_d;
    eq_q    <= eq_d;
    p95_q   <= p95_d;
    res_q   <= res_d;
  end

  assign out_valid_o = ov_q;
  assign res_o       = res_q;

endmodule

FILE: sv/frame_window_analyzer_top.sv
// Frame window analyzer: front classifier, job queue and window statistics back end.
// A frame passes the two-entry queue, then the back end, whose time is set mostly by the
// percentile rank sweep: each candidate is ranked against all n frames held, through the
// one read port of the window memory; under MIN_VALID frames the statistics are skipped.
// The back end takes a new frame only after the last; the queue takes frames meanwhile.
// Reset: asynchronous active low; clears ring pointers, counts and queue;
// window memory contents stay undefined and need no clearing pass.
module frame_window_analyzer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [19:0] frame_time_us_i,
  input  logic [19:0] gpu_time_us_i,
  input  logic [15:0] frames_per_sec_i,
  input  logic [9:0]  cpu_load_tenths_i,
  input  logic [39:0] mem_allocated_i,
  input  logic [39:0] mem_reserved_i,
  input  logic [19:0] draw_call_count_i,
  input  logic [10:0] cache_hit_ratio_i,
  input  logic [10:0] fragmentation_ratio_i,
  input  logic [15:0] shader_switch_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  bottleneck_class_o,
  output logic        too_many_draws_o,
  output logic        low_cache_hits_o,
  output logic        high_fragmentation_o,
  output logic        too_many_switches_o,
  output logic        analysis_valid_o,
  output logic [15:0] mean_fps_o,
  output logic [19:0] p95_frame_time_us_o,
  output logic [19:0] frame_time_stddev_us_o,
  output logic [7:0]  drop_count_o,
  output logic [7:0]  stutter_count_o
);

  logic              job_valid, job_pop;
  fwa_pkg::fwa_job_t job;
  fwa_pkg::fwa_res_t res;

  fwa_front u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .frame_time_us_i       (frame_time_us_i),
    .gpu_time_us_i         (gpu_time_us_i),
    .frames_per_sec_i      (frames_per_sec_i),
    .cpu_load_tenths_i     (cpu_load_tenths_i),
    .mem_allocated_i       (mem_allocated_i),
    .mem_reserved_i        (mem_reserved_i),
    .draw_call_count_i     (draw_call_count_i),
    .cache_hit_ratio_i     (cache_hit_ratio_i),
    .fragmentation_ratio_i (fragmentation_ratio_i),
    .shader_switch_count_i (shader_switch_count_i),
    .job_valid_o           (job_valid),
    .job_pop_i             (job_pop),
    .job_o                 (job)
  );

  fwa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .job_i       (job),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  // Result fields
  assign bottleneck_class_o     = res.cls;
  assign too_many_draws_o       = res.draws;
  assign low_cache_hits_o       = res.cache;
  assign high_fragmentation_o   = res.frag;
  assign too_many_switches_o    = res.switches;
  assign analysis_valid_o       = res.valid;
  assign mean_fps_o             = res.mean_fps;
  assign p95_frame_time_us_o    = res.p95;
  assign frame_time_stddev_us_o = res.stddev;
  assign drop_count_o           = res.drops;
  assign stutter_count_o        = res.stutters;

endmodule
